// ===== rtl/crn_pkg.sv =====
`timescale 1ns / 1ps

package crn_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int PTR_W      = 8;
    localparam int SPAN       = 256;
    localparam int POW_W      = 32;
    localparam int SUM_W      = 40;
    localparam int POS_W      = 16;
    localparam int D_W        = 9;
    localparam int SQ_W       = 31;
    localparam int A_W        = 39;
    localparam int FRAC_SHIFT = 31;
    localparam int DIVD_W     = A_W + FRAC_SHIFT;
    localparam int CNT_W      = 7;
    localparam int DIV_STEPS  = DIVD_W;
    localparam int SQRT_STEPS = 32;
    localparam int ADDR_W     = 3;

    localparam logic [7:0] GUARD_RESET  = 8'd2;
    localparam logic [7:0] WINDOW_RESET = 8'd16;

    // Register select is address bit 2 (one 32-bit word per register).
    localparam logic REG_GUARD  = 1'b0;
    localparam logic REG_WINDOW = 1'b1;

    localparam logic [1:0] STAT_NORM  = 2'd0;
    localparam logic [1:0] STAT_PASS  = 2'd1;
    localparam logic [1:0] STAT_NOREF = 2'd2;
    localparam logic [1:0] STAT_ZERO  = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_re;
        logic signed [SAMPLE_W-1:0] sample_im;
        logic                       first_of_line;
    } in_t;

    typedef struct packed {
        logic signed [31:0] norm_re;
        logic signed [31:0] norm_im;
        logic [1:0]         cfar_status;
    } out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_RE,
        S_SQ_IM,
        S_WRITE,
        S_RD_ADD,
        S_RD_SUB,
        S_SUM_SUB,
        S_CLASSIFY,
        S_MUL_A,
        S_DIV_INIT,
        S_DIV,
        S_SQRT_INIT,
        S_SQRT,
        S_STORE,
        S_DONE
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_RE,
        OP_SQ_IM,
        OP_WRITE,
        OP_RD_ADD,
        OP_RD_SUB,
        OP_SUM_SUB,
        OP_CLASSIFY,
        OP_MUL_A,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_STORE,
        OP_OUTPUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   part_im;
    } cmd_t;

    typedef struct packed {
        logic normalize;
        logic iter_last;
        logic out_busy;
    } stat_t;

endpackage

// ===== rtl/cfar_range_normalizer.sv =====
`timescale 1ns / 1ps

// Cell-averaging CFAR range normalizer.
// Input channel s_valid/s_ready/s_data carries one complex range sample per
// transaction, with first_of_line marking position zero of a range line.
// Output channel m_valid/m_ready/m_data returns one normalized Q16.16 sample
// and a status code per input transaction, in order.
// The APB port sets guard_cells (offset 0) and window_cells (offset 4); write
// it only while no sample is in flight.
// For a normalized sample the real and imaginary parts go in turn through
// one restoring divider and one bit-pair square root unit. Passed,
// no-reference and zero-power samples skip both units. A new sample is taken
// only once the previous result has moved to the output register; the next
// sample is taken while the previous result still waits on m_ready.
// When the receiver stalls, a finished result holds in the output register
// and the block stops before loading the next one.
// Reset clears the line position, ring pointer, reference sum, the ring's
// per-entry valid bits and the registers to their defaults (2 and 16).
module cfar_range_normalizer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  crn_pkg::in_t                s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output crn_pkg::out_t               m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [crn_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [7:0]     guard_reg, window_reg;
    crn_pkg::cmd_t  cmd;
    crn_pkg::stat_t stat;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            guard_reg  <= crn_pkg::GUARD_RESET;
            window_reg <= crn_pkg::WINDOW_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                crn_pkg::REG_GUARD:  guard_reg  <= pwdata[7:0];
                crn_pkg::REG_WINDOW: window_reg <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            crn_pkg::REG_GUARD:  prdata = {24'd0, guard_reg};
            crn_pkg::REG_WINDOW: prdata = {24'd0, window_reg};
            default:             prdata = '0;
        endcase
    end

    crn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    crn_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_data       (s_data),
        .guard_cells  (guard_reg),
        .window_cells (window_reg),
        .cmd          (cmd),
        .stat         (stat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule

// ===== rtl/crn_ctrl.sv =====
`timescale 1ns / 1ps

module crn_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  crn_pkg::stat_t stat,
    output crn_pkg::cmd_t  cmd
);

    crn_pkg::ctrl_state_t state_reg, state_next;
    logic                 part_reg, part_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= crn_pkg::S_IDLE;
            part_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            part_reg  <= part_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        part_next   = part_reg;
        s_ready     = 1'b0;
        cmd.op      = crn_pkg::OP_NONE;
        cmd.part_im = part_reg;
        case (state_reg)
            crn_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = crn_pkg::OP_LOAD;
                    state_next = crn_pkg::S_SQ_RE;
                end
            end
            crn_pkg::S_SQ_RE: begin
                cmd.op     = crn_pkg::OP_SQ_RE;
                state_next = crn_pkg::S_SQ_IM;
            end
            crn_pkg::S_SQ_IM: begin
                cmd.op     = crn_pkg::OP_SQ_IM;
                state_next = crn_pkg::S_WRITE;
            end
            crn_pkg::S_WRITE: begin
                cmd.op     = crn_pkg::OP_WRITE;
                state_next = crn_pkg::S_RD_ADD;
            end
            crn_pkg::S_RD_ADD: begin
                cmd.op     = crn_pkg::OP_RD_ADD;
                state_next = crn_pkg::S_RD_SUB;
            end
            crn_pkg::S_RD_SUB: begin
                cmd.op     = crn_pkg::OP_RD_SUB;
                state_next = crn_pkg::S_SUM_SUB;
            end
            crn_pkg::S_SUM_SUB: begin
                cmd.op     = crn_pkg::OP_SUM_SUB;
                state_next = crn_pkg::S_CLASSIFY;
            end
            crn_pkg::S_CLASSIFY: begin
                cmd.op     = crn_pkg::OP_CLASSIFY;
                part_next  = 1'b0;
                state_next = stat.normalize ? crn_pkg::S_MUL_A : crn_pkg::S_DONE;
            end
            crn_pkg::S_MUL_A: begin
                cmd.op     = crn_pkg::OP_MUL_A;
                state_next = crn_pkg::S_DIV_INIT;
            end
            crn_pkg::S_DIV_INIT: begin
                cmd.op     = crn_pkg::OP_DIV_INIT;
                state_next = crn_pkg::S_DIV;
            end
            crn_pkg::S_DIV: begin
                cmd.op = crn_pkg::OP_DIV_STEP;
                if (stat.iter_last) begin
                    state_next = crn_pkg::S_SQRT_INIT;
                end
            end
            crn_pkg::S_SQRT_INIT: begin
                cmd.op     = crn_pkg::OP_SQRT_INIT;
                state_next = crn_pkg::S_SQRT;
            end
            crn_pkg::S_SQRT: begin
                cmd.op = crn_pkg::OP_SQRT_STEP;
                if (stat.iter_last) begin
                    state_next = crn_pkg::S_STORE;
                end
            end
            crn_pkg::S_STORE: begin
                cmd.op = crn_pkg::OP_STORE;
                if (part_reg) begin
                    state_next = crn_pkg::S_DONE;
                end else begin
                    part_next  = 1'b1;
                    state_next = crn_pkg::S_MUL_A;
                end
            end
            crn_pkg::S_DONE: begin
                if (!stat.out_busy) begin
                    cmd.op     = crn_pkg::OP_OUTPUT;
                    state_next = crn_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = crn_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/crn_dp.sv =====
`timescale 1ns / 1ps

module crn_dp (
    input  logic           aclk,
    input  logic           aresetn,
    input  crn_pkg::in_t   s_data,
    input  logic [7:0]     guard_cells,
    input  logic [7:0]     window_cells,
    input  crn_pkg::cmd_t  cmd,
    output crn_pkg::stat_t stat,
    output logic           m_valid,
    input  logic           m_ready,
    output crn_pkg::out_t  m_data
);

    localparam int PROD_W = crn_pkg::SQ_W + 16;

    logic signed [crn_pkg::SAMPLE_W-1:0] re_reg, im_reg;
    logic [crn_pkg::SAMPLE_W-1:0]        ax_re_reg, ax_im_reg;
    logic [crn_pkg::POS_W-1:0]           pos_reg, i_reg;
    logic [crn_pkg::PTR_W-1:0]           ptr_reg;
    logic [crn_pkg::SUM_W-1:0]           sum_reg;
    logic [crn_pkg::SQ_W-1:0]            sq_re_reg, sq_im_reg;
    logic [crn_pkg::POW_W-1:0]           mem [crn_pkg::SPAN];
    logic [crn_pkg::SPAN-1:0]            vld_reg;
    logic [crn_pkg::POW_W-1:0]           rd_data_reg;
    logic                                rd_vld_reg;
    logic [crn_pkg::D_W-1:0]             d_reg;
    logic [1:0]                          status_reg;
    logic [31:0]                         res_re_reg, res_im_reg;
    logic [crn_pkg::A_W-1:0]             a_reg;
    logic                                dsat_reg;
    logic [crn_pkg::DIVD_W-1:0]          n_reg;
    logic [crn_pkg::SUM_W-1:0]           rem_reg;
    logic [63:0]                         rt_v_reg, rt_res_reg, rt_one_reg;
    logic [crn_pkg::CNT_W-1:0]           cnt_reg;
    logic                                m_valid_reg;
    crn_pkg::out_t                       m_data_reg;

    logic [7:0]                  w_eff;
    logic [8:0]                  gw;
    logic [9:0]                  gw1;
    logic                        rd_en;
    logic [crn_pkg::PTR_W-1:0]   rd_addr;
    logic [crn_pkg::POW_W-1:0]   rd_val;
    logic [crn_pkg::POW_W-1:0]   pw;
    logic [crn_pkg::SQ_W-1:0]    mul_a;
    logic [15:0]                 mul_b;
    logic [PROD_W-1:0]           prod;
    logic [crn_pkg::SUM_W:0]     sum_add;
    logic [1:0]                  status_c;
    logic [31:0]                 pass_re, pass_im, sat_re, sat_im;
    logic [crn_pkg::SUM_W:0]     div_t;
    logic                        div_ge;
    logic [63:0]                 rt_try;
    logic signed [crn_pkg::SAMPLE_W-1:0] x_sel;
    logic                        part_sat;
    logic [31:0]                 part_val;

    assign w_eff   = (window_cells == 8'd0) ? 8'd1 : window_cells;
    assign gw      = {1'b0, guard_cells} + {1'b0, w_eff};
    assign gw1     = {1'b0, gw} + 10'd1;
    assign rd_en   = (cmd.op == crn_pkg::OP_RD_ADD) || (cmd.op == crn_pkg::OP_RD_SUB);
    assign rd_addr = (cmd.op == crn_pkg::OP_RD_ADD) ? ptr_reg - guard_cells
                                                    : ptr_reg - gw1[7:0];
    assign rd_val  = rd_vld_reg ? rd_data_reg : '0;
    // Two squares of at most 2^30 each: the power never needs saturation.
    assign pw      = {1'b0, sq_re_reg} + {1'b0, sq_im_reg};
    assign sum_add = {1'b0, sum_reg} + {9'd0, rd_val};

    always_comb begin
        case (cmd.op)
            crn_pkg::OP_SQ_RE: begin
                mul_a = {15'd0, ax_re_reg};
                mul_b = ax_re_reg;
            end
            crn_pkg::OP_SQ_IM: begin
                mul_a = {15'd0, ax_im_reg};
                mul_b = ax_im_reg;
            end
            default: begin
                mul_a = cmd.part_im ? sq_im_reg : sq_re_reg;
                mul_b = {7'd0, d_reg};
            end
        endcase
        prod = {16'd0, mul_a} * {{crn_pkg::SQ_W{1'b0}}, mul_b};
    end

    always_comb begin
        if (i_reg == '0) begin
            status_c = crn_pkg::STAT_PASS;
        end else if (i_reg < {8'd0, guard_cells}) begin
            status_c = crn_pkg::STAT_NOREF;
        end else if (sum_reg == '0) begin
            status_c = crn_pkg::STAT_ZERO;
        end else begin
            status_c = crn_pkg::STAT_NORM;
        end
        pass_re = {re_reg, 16'd0};
        pass_im = {im_reg, 16'd0};
        sat_re  = (re_reg == '0) ? 32'd0 : (re_reg[15] ? 32'h8000_0000 : 32'h7FFF_FFFF);
        sat_im  = (im_reg == '0) ? 32'd0 : (im_reg[15] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    end

    always_comb begin
        div_t    = {rem_reg, n_reg[crn_pkg::DIVD_W-1]};
        div_ge   = div_t >= {1'b0, sum_reg};
        rt_try   = rt_res_reg + rt_one_reg;
        x_sel    = cmd.part_im ? im_reg : re_reg;
        part_sat = dsat_reg || (rt_res_reg[63:31] != '0);
        if (part_sat) begin
            part_val = cmd.part_im ? sat_im : sat_re;
        end else if (x_sel[15]) begin
            part_val = 32'd0 - rt_res_reg[31:0];
        end else begin
            part_val = rt_res_reg[31:0];
        end
    end

    // Ring storage; entries never written read as zero through the valid bits.
    always_ff @(posedge aclk) begin
        if (cmd.op == crn_pkg::OP_WRITE) begin
            mem[ptr_reg] <= pw;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (cmd.op == crn_pkg::OP_WRITE) begin
                vld_reg[ptr_reg] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            ptr_reg     <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (cmd.op)
                crn_pkg::OP_LOAD: begin
                    if (s_data.first_of_line) begin
                        sum_reg <= '0;
                    end
                end
                crn_pkg::OP_RD_SUB: begin
                    if (i_reg >= {8'd0, guard_cells}) begin
                        sum_reg <= sum_add[crn_pkg::SUM_W] ? '1 : sum_add[crn_pkg::SUM_W-1:0];
                    end
                end
                crn_pkg::OP_SUM_SUB: begin
                    if (i_reg > {7'd0, gw}) begin
                        sum_reg <= (sum_reg >= {8'd0, rd_val}) ? sum_reg - {8'd0, rd_val} : '0;
                    end
                end
                crn_pkg::OP_CLASSIFY: begin
                    ptr_reg <= ptr_reg + 1'b1;
                    pos_reg <= (i_reg == '1) ? i_reg : i_reg + 1'b1;
                end
                default: begin
                end
            endcase
            if (cmd.op == crn_pkg::OP_OUTPUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            crn_pkg::OP_LOAD: begin
                re_reg    <= s_data.sample_re;
                im_reg    <= s_data.sample_im;
                ax_re_reg <= s_data.sample_re[15] ? 16'd0 - s_data.sample_re
                                                  : s_data.sample_re;
                ax_im_reg <= s_data.sample_im[15] ? 16'd0 - s_data.sample_im
                                                  : s_data.sample_im;
                i_reg     <= s_data.first_of_line ? '0 : pos_reg;
            end
            crn_pkg::OP_SQ_RE: begin
                sq_re_reg <= prod[crn_pkg::SQ_W-1:0];
            end
            crn_pkg::OP_SQ_IM: begin
                sq_im_reg <= prod[crn_pkg::SQ_W-1:0];
            end
            crn_pkg::OP_CLASSIFY: begin
                status_reg <= status_c;
                d_reg      <= (i_reg < {7'd0, gw}) ? i_reg[crn_pkg::D_W-1:0] : {1'b0, w_eff};
                case (status_c)
                    crn_pkg::STAT_PASS: begin
                        res_re_reg <= pass_re;
                        res_im_reg <= pass_im;
                    end
                    crn_pkg::STAT_ZERO: begin
                        res_re_reg <= sat_re;
                        res_im_reg <= sat_im;
                    end
                    default: begin
                        res_re_reg <= '0;
                        res_im_reg <= '0;
                    end
                endcase
            end
            crn_pkg::OP_MUL_A: begin
                a_reg <= prod[crn_pkg::A_W-1:0];
            end
            crn_pkg::OP_DIV_INIT: begin
                // A quotient of 2^62 or more gives a square root past the Q16.16 range.
                dsat_reg <= {32'd0, a_reg} >= {sum_reg, 31'd0};
                n_reg    <= {a_reg, 31'd0};
                rem_reg  <= '0;
                cnt_reg  <= crn_pkg::CNT_W'(crn_pkg::DIV_STEPS - 1);
            end
            crn_pkg::OP_DIV_STEP: begin
                rem_reg <= div_ge ? div_t[crn_pkg::SUM_W-1:0] - sum_reg
                                  : div_t[crn_pkg::SUM_W-1:0];
                n_reg   <= {n_reg[crn_pkg::DIVD_W-2:0], div_ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            crn_pkg::OP_SQRT_INIT: begin
                rt_v_reg   <= {2'd0, n_reg[61:0]};
                rt_res_reg <= '0;
                rt_one_reg <= 64'h4000_0000_0000_0000;
                cnt_reg    <= crn_pkg::CNT_W'(crn_pkg::SQRT_STEPS - 1);
            end
            crn_pkg::OP_SQRT_STEP: begin
                if (rt_v_reg >= rt_try) begin
                    rt_v_reg   <= rt_v_reg - rt_try;
                    rt_res_reg <= (rt_res_reg >> 1) + rt_one_reg;
                end else begin
                    rt_res_reg <= rt_res_reg >> 1;
                end
                rt_one_reg <= rt_one_reg >> 2;
                cnt_reg    <= cnt_reg - 1'b1;
            end
            crn_pkg::OP_STORE: begin
                if (cmd.part_im) begin
                    res_im_reg <= part_val;
                end else begin
                    res_re_reg <= part_val;
                end
            end
            crn_pkg::OP_OUTPUT: begin
                m_data_reg.norm_re     <= res_re_reg;
                m_data_reg.norm_im     <= res_im_reg;
                m_data_reg.cfar_status <= status_reg;
            end
            default: begin
            end
        endcase
    end

    assign stat.normalize = (status_c == crn_pkg::STAT_NORM);
    assign stat.iter_last = (cnt_reg == '0);
    assign stat.out_busy  = m_valid_reg && !m_ready;
    assign m_valid        = m_valid_reg;
    assign m_data         = m_data_reg;

`ifndef NO_ASSERTIONS
    a_ptr_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == crn_pkg::OP_CLASSIFY) |=> (ptr_reg == $past(ptr_reg) + 1'b1))
        else $error("ring pointer did not advance by one per item");
    a_rem_below_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == crn_pkg::OP_DIV_STEP) |-> (rem_reg < sum_reg))
        else $error("division remainder reached the reference sum");
    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == crn_pkg::OP_STORE && !dsat_reg) |-> (rt_res_reg[63:31] == '0))
        else $error("square root exceeded 31 bits without saturation flag");
    a_output_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == crn_pkg::OP_OUTPUT) |-> (!m_valid_reg || m_ready))
        else $error("result loaded over an untaken result");
`endif

endmodule
